### sv/abt_pkg.sv
package abt_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned NumCols = 4;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] row0_col0;
    logic signed [CoordW-1:0] row0_col1;
    logic signed [CoordW-1:0] row0_col2;
    logic signed [CoordW-1:0] row0_col3;
    logic signed [CoordW-1:0] row1_col0;
    logic signed [CoordW-1:0] row1_col1;
    logic signed [CoordW-1:0] row1_col2;
    logic signed [CoordW-1:0] row1_col3;
    logic signed [CoordW-1:0] row2_col0;
    logic signed [CoordW-1:0] row2_col1;
    logic signed [CoordW-1:0] row2_col2;
    logic signed [CoordW-1:0] row2_col3;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_min_x;
    logic signed [CoordW-1:0] out_min_y;
    logic signed [CoordW-1:0] out_min_z;
    logic signed [CoordW-1:0] out_max_x;
    logic signed [CoordW-1:0] out_max_y;
    logic signed [CoordW-1:0] out_max_z;
    logic                     saturated;
  } out_t;

endpackage

### sv/aabb_transform_bounds_top.sv
// Channel  Direction  Handshake          Payload
// in_      request    in_valid/in_ready  abt_pkg::in_t, 3x4 Q16.16 matrix
// out_     result     out_valid/out_ready abt_pkg::out_t, transformed box and flag
// cfg_     register   APB write/read     six Q16.16 box corner registers
//
// One request is taken every cycle unless the output stalls; results leave from out_r.
// The clock period is set by stage one, which holds eighteen 32x32 multipliers, one per
// matrix entry and box corner value, followed by compare, add, round and clamp stages.
// Reset is synchronous and active low; it clears the box registers and all valid bits.
// A stalled output holds each stage whose successor is full; bubbles are squeezed out.
module aabb_transform_bounds_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  abt_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output abt_pkg::out_t        out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int unsigned W   = abt_pkg::CoordW;
  localparam int unsigned NA  = abt_pkg::NumAxes;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned RW  = SW - 16 + 1;
  localparam logic signed [SW-1:0] RoundHalf = SW'(32768);
  localparam logic signed [RW-1:0] SatMax = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] SatMin = -RW'(64'sd2147483648);

  logic signed [W-1:0] box_lo_r [NA];
  logic signed [W-1:0] box_hi_r [NA];
  logic                cfg_wr;
  abt_pkg::reg_idx_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = abt_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        box_lo_r[i] <= '0;
        box_hi_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        abt_pkg::REG_BOX_MIN_X: box_lo_r[0] <= cfg_pwdata;
        abt_pkg::REG_BOX_MIN_Y: box_lo_r[1] <= cfg_pwdata;
        abt_pkg::REG_BOX_MIN_Z: box_lo_r[2] <= cfg_pwdata;
        abt_pkg::REG_BOX_MAX_X: box_hi_r[0] <= cfg_pwdata;
        abt_pkg::REG_BOX_MAX_Y: box_hi_r[1] <= cfg_pwdata;
        abt_pkg::REG_BOX_MAX_Z: box_hi_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      abt_pkg::REG_BOX_MIN_X: cfg_prdata = box_lo_r[0];
      abt_pkg::REG_BOX_MIN_Y: cfg_prdata = box_lo_r[1];
      abt_pkg::REG_BOX_MIN_Z: cfg_prdata = box_lo_r[2];
      abt_pkg::REG_BOX_MAX_X: cfg_prdata = box_hi_r[0];
      abt_pkg::REG_BOX_MAX_Y: cfg_prdata = box_hi_r[1];
      abt_pkg::REG_BOX_MAX_Z: cfg_prdata = box_hi_r[2];
      default:                cfg_prdata = '0;
    endcase
  end

  logic signed [W-1:0] mat [NA][abt_pkg::NumCols];

  always_comb begin
    mat[0][0] = in_data.row0_col0;
    mat[0][1] = in_data.row0_col1;
    mat[0][2] = in_data.row0_col2;
    mat[0][3] = in_data.row0_col3;
    mat[1][0] = in_data.row1_col0;
    mat[1][1] = in_data.row1_col1;
    mat[1][2] = in_data.row1_col2;
    mat[1][3] = in_data.row1_col3;
    mat[2][0] = in_data.row2_col0;
    mat[2][1] = in_data.row2_col1;
    mat[2][2] = in_data.row2_col2;
    mat[2][3] = in_data.row2_col3;
  end

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  assign rdy_out  = out_ready | ~out_v_r;
  assign rdy4     = rdy_out | ~s4_v_r;
  assign rdy3     = rdy4 | ~s3_v_r;
  assign rdy2     = rdy3 | ~s2_v_r;
  assign rdy1     = rdy2 | ~s1_v_r;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)    s1_v_r  <= in_valid;
      if (rdy2)    s2_v_r  <= s1_v_r;
      if (rdy3)    s3_v_r  <= s2_v_r;
      if (rdy4)    s4_v_r  <= s3_v_r;
      if (rdy_out) out_v_r <= s4_v_r;
    end
  end

  // Every corner picks each box coordinate independently from the lower or upper
  // value, so the extreme of a row's sum over the corners is the sum of the
  // per-term extremes. Rounding and clamping are monotonic, so the order holds.
  logic signed [PW-1:0] s1_plo_r [NA][NA];
  logic signed [PW-1:0] s1_phi_r [NA][NA];
  logic signed [W-1:0]  s1_t_r   [NA];
  logic signed [PW-1:0] s2_min_r [NA][NA];
  logic signed [PW-1:0] s2_max_r [NA][NA];
  logic signed [W-1:0]  s2_t_r   [NA];
  logic signed [SW-1:0] s3_min_r [NA];
  logic signed [SW-1:0] s3_max_r [NA];
  logic signed [W-1:0]  s3_t_r   [NA];
  logic signed [RW-1:0] s4_min_r [NA];
  logic signed [RW-1:0] s4_max_r [NA];
  abt_pkg::out_t        out_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int r = 0; r < NA; r++) begin
        for (int c = 0; c < NA; c++) begin
          s1_plo_r[r][c] <= PW'(mat[r][c]) * PW'(box_lo_r[c]);
          s1_phi_r[r][c] <= PW'(mat[r][c]) * PW'(box_hi_r[c]);
        end
        s1_t_r[r] <= mat[r][3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      for (int r = 0; r < NA; r++) begin
        for (int c = 0; c < NA; c++) begin
          if (s1_plo_r[r][c] < s1_phi_r[r][c]) begin
            s2_min_r[r][c] <= s1_plo_r[r][c];
            s2_max_r[r][c] <= s1_phi_r[r][c];
          end else begin
            s2_min_r[r][c] <= s1_phi_r[r][c];
            s2_max_r[r][c] <= s1_plo_r[r][c];
          end
        end
        s2_t_r[r] <= s1_t_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      for (int r = 0; r < NA; r++) begin
        s3_min_r[r] <= SW'(s2_min_r[r][0]) + SW'(s2_min_r[r][1]) + SW'(s2_min_r[r][2])
                       + RoundHalf;
        s3_max_r[r] <= SW'(s2_max_r[r][0]) + SW'(s2_max_r[r][1]) + SW'(s2_max_r[r][2])
                       + RoundHalf;
        s3_t_r[r]   <= s2_t_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      for (int r = 0; r < NA; r++) begin
        s4_min_r[r] <= RW'($signed(s3_min_r[r][SW-1:16])) + RW'(s3_t_r[r]);
        s4_max_r[r] <= RW'($signed(s3_max_r[r][SW-1:16])) + RW'(s3_t_r[r]);
      end
    end
  end

  function automatic logic signed [W-1:0] clamp(input logic signed [RW-1:0] v);
    logic signed [W-1:0] res;
    if (v > SatMax) begin
      res = SatMax[W-1:0];
    end else if (v < SatMin) begin
      res = SatMin[W-1:0];
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  logic sat_any;

  always_comb begin
    sat_any = 1'b0;
    for (int r = 0; r < NA; r++) begin
      if (s4_min_r[r] < SatMin || s4_max_r[r] > SatMax) begin
        sat_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && s4_v_r) begin
      out_r.out_min_x <= clamp(s4_min_r[0]);
      out_r.out_min_y <= clamp(s4_min_r[1]);
      out_r.out_min_z <= clamp(s4_min_r[2]);
      out_r.out_max_x <= clamp(s4_max_r[0]);
      out_r.out_max_y <= clamp(s4_max_r[1]);
      out_r.out_max_z <= clamp(s4_max_r[2]);
      out_r.saturated <= sat_any;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.out_min_x <= out_r.out_max_x) &&
                (out_r.out_min_y <= out_r.out_max_y) &&
                (out_r.out_min_z <= out_r.out_max_z))
    else $error("transformed box has minimum above maximum");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted request did not enter the first stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !rdy_out) |=> (s4_v_r && $stable(s4_min_r[0]) && $stable(s4_max_r[2])))
    else $error("last stage lost or changed its request under a stall");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && rdy4) |=> s4_v_r)
    else $error("request was dropped between the sum and rounding stages");
`endif

endmodule

### tb/sv/aabb_transform_bounds_checker.sv
`timescale 1ns / 1ps

module aabb_transform_bounds_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  abt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  abt_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [4:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  input  logic [31:0]   cfg_prdata,
  input  logic          cfg_pready,
  output int            mismatches,
  output int            pending,
  output int            results_checked,
  output int            saturated_results
);

  // Shadow of the box registers, held in register index order.
  logic signed [31:0] box_regs [6];
  abt_pkg::out_t      expected_boxes [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want) begin
      report_mismatch($sformatf("%s is %h, predicted %h", name, seen, want));
    end
  endtask

  // One corner coordinate: exact sum of products, rounded to Q16.16 with ties
  // going up, then the translation, then clamped to 32 bits.
  function automatic logic signed [31:0] transform_coord(
    input logic signed [31:0] a, b, c, t, x, y, z,
    inout logic clipped
  );
    logic signed [67:0] acc;
    acc = a * x + b * y + c * z + 68'sd32768;
    acc = (acc >>> 16) + t;
    if (acc > 68'sd2147483647) begin
      clipped = 1'b1;
      acc = 68'sd2147483647;
    end
    if (acc < -68'sd2147483648) begin
      clipped = 1'b1;
      acc = -68'sd2147483648;
    end
    return acc[31:0];
  endfunction

  function automatic abt_pkg::out_t transformed_bounds(input abt_pkg::in_t m);
    logic signed [31:0] rows [3][4];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] x, y, z, v;
    logic               clipped;
    abt_pkg::out_t      r;
    rows[0] = '{m.row0_col0, m.row0_col1, m.row0_col2, m.row0_col3};
    rows[1] = '{m.row1_col0, m.row1_col1, m.row1_col2, m.row1_col3};
    rows[2] = '{m.row2_col0, m.row2_col1, m.row2_col2, m.row2_col3};
    clipped = 1'b0;
    for (int k = 0; k < 8; k++) begin
      x = (k & 1) ? box_regs[abt_pkg::REG_BOX_MAX_X] : box_regs[abt_pkg::REG_BOX_MIN_X];
      y = (k & 2) ? box_regs[abt_pkg::REG_BOX_MAX_Y] : box_regs[abt_pkg::REG_BOX_MIN_Y];
      z = (k & 4) ? box_regs[abt_pkg::REG_BOX_MAX_Z] : box_regs[abt_pkg::REG_BOX_MIN_Z];
      for (int ax = 0; ax < 3; ax++) begin
        v = transform_coord(rows[ax][0], rows[ax][1], rows[ax][2], rows[ax][3],
                            x, y, z, clipped);
        if (k == 0 || v < lo[ax]) lo[ax] = v;
        if (k == 0 || v > hi[ax]) hi[ax] = v;
      end
    end
    r.out_min_x = lo[0];
    r.out_min_y = lo[1];
    r.out_min_z = lo[2];
    r.out_max_x = hi[0];
    r.out_max_y = hi[1];
    r.out_max_z = hi[2];
    r.saturated = clipped;
    return r;
  endfunction

  always @(posedge clk) begin
    abt_pkg::out_t want;
    if (!rst_n) begin
      foreach (box_regs[i]) box_regs[i] = '0;
      expected_boxes.delete();
      mismatches = 0;
      results_checked = 0;
      saturated_results = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[4:2] <= abt_pkg::REG_BOX_MAX_Z) begin
        if (cfg_pwrite) begin
          box_regs[cfg_paddr[4:2]] = cfg_pwdata;
        end else begin
          check_field($sformatf("register %0d read", cfg_paddr[4:2]), cfg_prdata,
                      box_regs[cfg_paddr[4:2]]);
        end
      end
      if (in_valid && in_ready) begin
        expected_boxes.insert(expected_boxes.size(), transformed_bounds(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_boxes.pop_front();
          check_field("out_min_x", out_data.out_min_x, want.out_min_x);
          check_field("out_min_y", out_data.out_min_y, want.out_min_y);
          check_field("out_min_z", out_data.out_min_z, want.out_min_z);
          check_field("out_max_x", out_data.out_max_x, want.out_max_x);
          check_field("out_max_y", out_data.out_max_y, want.out_max_y);
          check_field("out_max_z", out_data.out_max_z, want.out_max_z);
          check_field("saturated", {31'b0, out_data.saturated}, {31'b0, want.saturated});
          results_checked++;
          if (want.saturated) saturated_results++;
        end
      end
    end
    pending = expected_boxes.size();
  end

endmodule

### tb/sv/aabb_transform_bounds_top_tb.sv
`timescale 1ns / 1ps

module aabb_transform_bounds_top_tb;

  localparam logic [2:0] SpareIdxLo = 3'd6;
  localparam logic [2:0] SpareIdxHi = 3'd7;
  localparam logic [31:0] QOne    = 32'h0001_0000;
  localparam logic [31:0] QNegOne = 32'hFFFF_0000;
  localparam logic [31:0] QHalf   = 32'h0000_8000;
  localparam logic [31:0] QMax    = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin    = 32'h8000_0000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  abt_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  abt_pkg::out_t out_data;
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [4:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  int mismatches, pending, results_checked, saturated_results;
  int requests_sent = 0;
  int settings_used = 0;
  bit idling = 1'b0;

  aabb_transform_bounds_top dut (.*);

  aabb_transform_bounds_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = !idling || ($urandom_range(99) >= 27);
  end

  initial begin
    #2_000_000;
    $display("aabb_transform_bounds_top verification failed");
    $finish;
  end

  task automatic cfg_access(input logic write, input logic [2:0] idx,
                            input logic [31:0] data);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = write;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic read_box();
    for (int i = abt_pkg::REG_BOX_MIN_X; i <= abt_pkg::REG_BOX_MAX_Z; i++) begin
      cfg_access(1'b0, i[2:0], '0);
    end
  endtask

  task automatic load_box(input logic [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_access(1'b1, abt_pkg::REG_BOX_MIN_X, lo_x);
    cfg_access(1'b1, abt_pkg::REG_BOX_MIN_Y, lo_y);
    cfg_access(1'b1, abt_pkg::REG_BOX_MIN_Z, lo_z);
    cfg_access(1'b1, abt_pkg::REG_BOX_MAX_X, hi_x);
    cfg_access(1'b1, abt_pkg::REG_BOX_MAX_Y, hi_y);
    cfg_access(1'b1, abt_pkg::REG_BOX_MAX_Z, hi_z);
    read_box();
    settings_used++;
  endtask

  task automatic send(input abt_pkg::in_t m);
    if (idling && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  function automatic abt_pkg::in_t affine(input logic [31:0] a0, a1, a2, a3,
                                          b0, b1, b2, b3, c0, c1, c2, c3);
    return '{a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3};
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] frac;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(32'h7_FFFF) - 32'h4_0000;
      6: return $urandom();
      7: begin
        case ($urandom_range(5))
          0: return QMax;
          1: return QMin;
          2: return '0;
          3: return QOne;
          4: return QNegOne;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      8: begin
        frac = $urandom_range(32'hFFFF);
        return $urandom_range(1) ? -frac : frac;
      end
      default: return $urandom_range(32'h3FF_FFFF) - 32'h200_0000;
    endcase
  endfunction

  function automatic abt_pkg::in_t rand_matrix();
    return '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    idling = 1'b1;

    send(affine(QOne, 0, 0, 0, 0, QOne, 0, 0, 0, 0, QOne, 0));

    load_box(QNegOne, 32'hFFFE_0000, 32'hFFFD_0000, QOne, 32'h0002_0000, 32'h0003_0000);
    cfg_access(1'b1, SpareIdxLo, 32'hDEAD_BEEF);
    cfg_access(1'b1, SpareIdxHi, 32'h1234_5678);
    read_box();
    send(affine(QOne, 0, 0, QHalf, 0, QOne, 0, 32'hFFFF_C000, 0, 0, QOne, 32'h0007_0000));
    send('0);
    send({12{QMax}});
    send({12{QMin}});
    send(affine(0, QNegOne, 0, QOne, 0, 0, QNegOne, 0, QNegOne, 0, 0, 32'hFFFE_8000));
    send(affine(QOne, 0, 0, QMax, 0, QOne, 0, QMin, 0, 0, QOne, 0));
    send(affine(QNegOne, 0, 0, QMin, 0, QNegOne, 0, QMax, 0, 0, QNegOne, QMin));

    // Box mostly in raw units, with the lower x bound above the upper one, to hit rounding ties.
    load_box(32'h1, 32'h1, QOne, 32'hFFFF_FFFF, 32'h3, QMax);
    send(affine(QHalf, 0, 0, 0, 0, 32'hFFFF_8000, 0, 0, 0, 0, QMax, 0));
    send(affine(QHalf, 0, 0, QMax, 0, QHalf, 0, QMin, 0, 0, 0, 32'h1));
    send(affine(32'hFFFF_8000, 0, 0, QMin, 32'hFFFF_8000, 0, 0, QMax, 0, 0, QHalf, 0));

    load_box(QMin, QMin, QMin, QMax, QMax, QMax);
    send(affine(QOne, 0, 0, 0, 0, QOne, 0, 0, 0, 0, QOne, 0));
    send(affine(QNegOne, 0, 0, 0, 0, QNegOne, 0, 0, 0, 0, QNegOne, 0));
    send({12{QMax}});
    send({12{QMin}});
    send({12{32'hFFFF_FFFF}});
    send(affine(0, 0, 0, $urandom(), 0, 0, 0, $urandom(), 0, 0, 0, $urandom()));

    for (int p = 0; p < 6; p++) begin
      load_box(rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord());
      idling = (p != 2);
      repeat (242) send(rand_matrix());
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d matrix requests across %0d box settings, including inverted,",
             requests_sent, settings_used);
    $display("full-range and rounding-tie boxes; %0d results compared, %0d saturated.",
             results_checked, saturated_results);
    if (mismatches == 0) begin
      $display("aabb_transform_bounds_top verification clean");
    end else begin
      $display("aabb_transform_bounds_top verification failed");
    end
    $finish;
  end

endmodule
